### sv/ftrs_pkg.sv
// Shared types and constants for the field taper ramp scaler.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ftrs_pkg;

  localparam int PART_W    = 32;
  localparam int NUM_PARTS = 6;
  localparam int Z_W       = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_TAPER_START = 2'd0;
  localparam cfg_idx_t CFG_TAPER_END   = 2'd1;
  localparam cfg_idx_t CFG_TAPER_MODE  = 2'd2;

  localparam logic MODE_LINEAR = 1'b0;
  localparam logic MODE_CUBIC  = 1'b1;

  localparam logic signed [Z_W-1:0] START_RST = 32'sd0;
  localparam logic signed [Z_W-1:0] END_RST   = 32'sd65536;

  // Data that rides alongside the quotient through the divider.
  typedef struct packed {
    logic                                le_start;
    logic                                ge_end;
    logic [NUM_PARTS-1:0][PART_W-1:0]    part;
  } ftrs_side_t;

endpackage

`default_nettype wire

### sv/ftrs_if.sv
// Channel interfaces of the field taper ramp scaler: input, result and config.
// Depends on ftrs_pkg for field widths.
`default_nettype none

interface ftrs_in_if import ftrs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [Z_W-1:0]    z_position;
  logic signed [PART_W-1:0] comp_x_re;
  logic signed [PART_W-1:0] comp_x_im;
  logic signed [PART_W-1:0] comp_y_re;
  logic signed [PART_W-1:0] comp_y_im;
  logic signed [PART_W-1:0] comp_z_re;
  logic signed [PART_W-1:0] comp_z_im;

  modport source (output valid, z_position, comp_x_re, comp_x_im, comp_y_re, comp_y_im,
                  comp_z_re, comp_z_im, input ready);
  modport sink (input valid, z_position, comp_x_re, comp_x_im, comp_y_re, comp_y_im,
                comp_z_re, comp_z_im, output ready);
endinterface

interface ftrs_out_if import ftrs_pkg::*; #(parameter int FRAC_BITS = 16) ();
  logic                     valid;
  logic                     ready;
  logic [FRAC_BITS:0]       ramp_factor;
  logic signed [PART_W-1:0] out_x_re;
  logic signed [PART_W-1:0] out_x_im;
  logic signed [PART_W-1:0] out_y_re;
  logic signed [PART_W-1:0] out_y_im;
  logic signed [PART_W-1:0] out_z_re;
  logic signed [PART_W-1:0] out_z_im;

  modport source (output valid, ramp_factor, out_x_re, out_x_im, out_y_re, out_y_im,
                  out_z_re, out_z_im, input ready);
  modport sink (input valid, ramp_factor, out_x_re, out_x_im, out_y_re, out_y_im,
                out_z_re, out_z_im, output ready);
endinterface

interface ftrs_cfg_if import ftrs_pkg::*; ();
  logic             valid;
  logic             ready;
  cfg_idx_t         index;
  logic [CFG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/ftrs_divider.sv
// Pipelined restoring divider: one quotient bit per stage, FRAC_BITS stages.
// Carries ftrs_side_t alongside; depends on ftrs_pkg.
`default_nettype none

module ftrs_divider import ftrs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [Z_W-1:0]       rem_in,
  input  wire logic [Z_W-1:0]       den_in,
  input  wire ftrs_side_t           side_in,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [FRAC_BITS-1:0]      quot_out,
  output ftrs_side_t                side_out
);

  logic                 v_r    [FRAC_BITS];
  logic [Z_W-1:0]       rem_r  [FRAC_BITS];
  logic [Z_W-1:0]       den_r  [FRAC_BITS];
  logic [FRAC_BITS-1:0] quot_r [FRAC_BITS];
  ftrs_side_t           side_r [FRAC_BITS];
  logic [FRAC_BITS-1:0] en;

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_stage
    logic                 v_in;
    logic [Z_W-1:0]       r_in;
    logic [Z_W-1:0]       d_in;
    logic [FRAC_BITS-1:0] q_in;
    ftrs_side_t           s_in;
    logic                 en_down;
    logic [Z_W:0]         shifted;
    logic                 fits;
    logic [Z_W:0]         diff;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = rem_in;
      assign d_in = den_in;
      assign q_in = '0;
      assign s_in = side_in;
    end else begin : g_next
      assign v_in = v_r[k-1];
      assign r_in = rem_r[k-1];
      assign d_in = den_r[k-1];
      assign q_in = quot_r[k-1];
      assign s_in = side_r[k-1];
    end

    if (k == FRAC_BITS - 1) begin : g_last
      assign en_down = out_ready;
    end else begin : g_mid
      assign en_down = en[k+1];
    end

    // A stage moves when it is empty or its successor moves, so bubbles close up.
    assign en[k] = !v_r[k] || en_down;

    assign shifted = {r_in, 1'b0};
    assign fits    = shifted >= {1'b0, d_in};
    assign diff    = shifted - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k]  <= fits ? diff[Z_W-1:0] : shifted[Z_W-1:0];
        den_r[k]  <= d_in;
        quot_r[k] <= {q_in[FRAC_BITS-2:0], fits};
        side_r[k] <= s_in;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[FRAC_BITS-1];
  assign quot_out  = quot_r[FRAC_BITS-1];
  assign side_out  = side_r[FRAC_BITS-1];

endmodule

`default_nettype wire

### sv/field_taper_ramp_scaler.sv
// Field taper ramp scaler top level: config registers, ramp pipeline, scaling.
// Depends on ftrs_pkg, the ftrs_*_if interfaces and ftrs_divider.
//
// Usage: each beat on in_chan carries a z position and six field parts. The
// block forms a taper factor from z (one before taper_start, zero from
// taper_end on, a linear or cubic ramp between) and returns on out_chan the
// factor and the six parts scaled by it. Both channels use valid/ready.
// cfg_chan writes taper_start, taper_end and taper_mode by index; it is always
// ready and should be written only while no beat is in flight.
// One beat is accepted per cycle until a receiver stall has filled the
// pipeline. The pipeline holds an operand stage, the divider, which resolves
// one quotient bit per pipeline stage, two multiply stages for the cubic
// term, a factor stage and a scaling stage.
// Reset clears every stage valid and loads the register defaults (start 0,
// end 1.0, linear mode). When the receiver stalls, the full stages hold their
// data, empty stages keep filling, and in_chan.ready falls only once the
// pipeline is completely full; nothing is dropped or repeated.
`default_nettype none

module field_taper_ramp_scaler import ftrs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ftrs_in_if.sink   in_chan,
  ftrs_out_if.source out_chan,
  ftrs_cfg_if.sink  cfg_chan
);

  localparam int FW = FRAC_BITS;
  localparam logic [FW:0] FAC_ONE = {1'b1, {FW{1'b0}}};

  // Configuration registers
  logic signed [Z_W-1:0] start_r;
  logic signed [Z_W-1:0] end_r;
  logic                  mode_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= START_RST;
      end_r   <= END_RST;
      mode_r  <= MODE_LINEAR;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_TAPER_START: start_r <= $signed(cfg_chan.data);
        CFG_TAPER_END:   end_r   <= $signed(cfg_chan.data);
        CFG_TAPER_MODE:  mode_r  <= cfg_chan.data[0];
        default: ;
      endcase
    end
  end

  // Stage 0: range tests and the divider operands
  logic           v0_r;
  logic [Z_W-1:0] diff0_r;
  logic [Z_W-1:0] den0_r;
  ftrs_side_t     side0_r;
  ftrs_side_t     side0_nxt;
  logic           en0;
  logic           div_in_ready;

  always_comb begin
    side0_nxt.le_start = in_chan.z_position <= start_r;
    side0_nxt.ge_end   = in_chan.z_position >= end_r;
    side0_nxt.part[0]  = in_chan.comp_x_re;
    side0_nxt.part[1]  = in_chan.comp_x_im;
    side0_nxt.part[2]  = in_chan.comp_y_re;
    side0_nxt.part[3]  = in_chan.comp_y_im;
    side0_nxt.part[4]  = in_chan.comp_z_re;
    side0_nxt.part[5]  = in_chan.comp_z_im;
  end

  assign en0           = !v0_r || div_in_ready;
  assign in_chan.ready = en0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en0) begin
      v0_r <= in_chan.valid;
    end
  end

  // Inside the ramp both differences are positive and below 2^32.
  always_ff @(posedge clk) begin
    if (en0) begin
      diff0_r <= in_chan.z_position - start_r;
      den0_r  <= end_r - start_r;
      side0_r <= side0_nxt;
    end
  end

  // Divider stages
  logic          div_valid;
  logic [FW-1:0] div_quot;
  ftrs_side_t    div_side;
  logic          en1;

  ftrs_divider #(.FRAC_BITS(FW)) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v0_r),
    .in_ready (div_in_ready),
    .rem_in   (diff0_r),
    .den_in   (den0_r),
    .side_in  (side0_r),
    .out_valid(div_valid),
    .out_ready(en1),
    .quot_out (div_quot),
    .side_out (div_side)
  );

  // Stage 1: d squared
  logic            v1_r;
  logic [FW-1:0]   d1_r;
  logic [FW-1:0]   sq1_r;
  ftrs_side_t      side1_r;
  logic [2*FW-1:0] sq_full;
  logic            en2;

  assign sq_full = div_quot * div_quot;
  assign en1     = !v1_r || en2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      d1_r    <= div_quot;
      sq1_r   <= sq_full[2*FW-1:FW];
      side1_r <= div_side;
    end
  end

  // Stage 2: d cubed
  logic            v2_r;
  logic [FW-1:0]   d2_r;
  logic [FW-1:0]   sq2_r;
  logic [FW-1:0]   cube2_r;
  ftrs_side_t      side2_r;
  logic [2*FW-1:0] cube_full;
  logic            en3;

  assign cube_full = sq1_r * d1_r;
  assign en2       = !v2_r || en3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      d2_r    <= d1_r;
      sq2_r   <= sq1_r;
      cube2_r <= cube_full[2*FW-1:FW];
      side2_r <= side1_r;
    end
  end

  // Stage 3: taper factor
  logic                  v3_r;
  logic [FW:0]           fac3_r;
  logic [FW:0]           fac3_nxt;
  ftrs_side_t            side3_r;
  logic signed [FW+3:0]  cubic;
  logic [FW+1:0]         sq_x3;
  logic                  en4;

  assign sq_x3 = {1'b0, sq2_r, 1'b0} + {2'b00, sq2_r};
  assign cubic = $signed({3'b000, FAC_ONE}) - $signed({2'b00, sq_x3})
               + $signed({3'b000, cube2_r, 1'b0});

  always_comb begin
    if (side2_r.le_start) begin
      fac3_nxt = FAC_ONE;
    end else if (side2_r.ge_end) begin
      fac3_nxt = '0;
    end else if (mode_r == MODE_LINEAR) begin
      fac3_nxt = FAC_ONE - {1'b0, d2_r};
    end else if (cubic[FW+3]) begin
      fac3_nxt = '0;
    end else if (cubic > $signed({3'b000, FAC_ONE})) begin
      fac3_nxt = FAC_ONE;
    end else begin
      fac3_nxt = cubic[FW:0];
    end
  end

  assign en3 = !v3_r || en4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      fac3_r  <= fac3_nxt;
      side3_r <= side2_r;
    end
  end

  // Stage 4: scale the six parts; the slice is the arithmetic shift by FRAC_BITS.
  logic                   v4_r;
  logic [FW:0]            fac4_r;
  logic [PART_W-1:0]      scaled4_r [NUM_PARTS];
  logic signed [FW+1:0]   fac_s;
  logic signed [PART_W+FW+1:0] prod [NUM_PARTS];

  assign fac_s = $signed({1'b0, fac3_r});

  for (genvar i = 0; i < NUM_PARTS; i++) begin : g_scale
    assign prod[i] = $signed(side3_r.part[i]) * fac_s;

    always_ff @(posedge clk) begin
      if (en4) begin
        scaled4_r[i] <= prod[i][PART_W+FW-1:FW];
      end
    end
  end

  assign en4 = !v4_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      fac4_r <= fac3_r;
    end
  end

  assign out_chan.valid       = v4_r;
  assign out_chan.ramp_factor = fac4_r;
  assign out_chan.out_x_re    = scaled4_r[0];
  assign out_chan.out_x_im    = scaled4_r[1];
  assign out_chan.out_y_re    = scaled4_r[2];
  assign out_chan.out_y_im    = scaled4_r[3];
  assign out_chan.out_z_re    = scaled4_r[4];
  assign out_chan.out_z_im    = scaled4_r[5];

`ifndef SYNTHESIS
  a_fac_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !en3) |=> (v3_r && $stable(fac3_r)))
    else $error("factor stage lost or changed a held item");

  a_fac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.ramp_factor <= FAC_ONE))
    else $error("taper factor above one");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid)
    else $error("result valid straight after reset");

  a_stall_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (!v4_r && v3_r) |=> v4_r)
    else $error("empty output stage did not take a waiting item");
`endif

endmodule

`default_nettype wire
